[rtl/core/srs_pkg.sv]
// Package for the selective-repeat ARQ sender: field widths, codes, and the
// command and status structs passed between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srs_pkg;

   // Widths of the transaction fields and of the register port.
   localparam int unsigned OP_W        = 1;
   localparam int unsigned ACK_W       = 4;
   localparam int unsigned FRAME_W     = 4;
   localparam int unsigned WIN_W       = 4;
   localparam int unsigned END_W       = 5;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned CSR_DATA_W  = 5;

   // Operation codes of a request.
   localparam logic [OP_W-1:0] OP_START = 1'b0;
   localparam logic [OP_W-1:0] OP_ACK   = 1'b1;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_END   = 2'd1;

   // Register reset values.
   localparam logic [WIN_W-1:0] WINDOW_SIZE_RST = 4'd4;
   localparam logic [END_W-1:0] FRAME_END_RST   = 5'd10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SLIDE,
      ST_RETX,
      ST_NEW,
      ST_STATUS
   } srs_state_type;

   typedef enum logic [1:0] {
      KIND_RETX,
      KIND_NEW,
      KIND_STATUS
   } srs_kind_type;

   typedef struct packed {
      logic         accept;
      logic         slide_step;
      logic         raise;
      logic         scan_step;
      logic         new_step;
      logic         emit;
      srs_kind_type kind;
   } srs_cmd_type;

   typedef struct packed {
      logic slide_more;
      logic retx_more;
      logic retx_hit;
      logic new_more;
      logic out_free;
   } srs_stat_type;

endpackage

`default_nettype wire

[rtl/core/selective_repeat_sender_unit.sv]
// Selective-repeat ARQ sender. One request transaction is handled at a time.
// A start runs the new-frame sends and then loads the status result; an
// acknowledgment first runs the slide steps (at most MAX_FRAMES) and the
// retransmission scan, then the new-frame sends and the status result.
// The next request is accepted the cycle after the status result is loaded.
// Synchronous active-high reset: base and next frame to one, bitmap cleared.
`timescale 1ns / 1ps
`default_nettype none

module selective_repeat_sender_unit
   import srs_pkg::*;
#(
   parameter int unsigned MAX_FRAMES = 16,
   parameter int unsigned MAX_WINDOW = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [OP_W-1:0]       req_operation,
   input  wire logic [ACK_W-1:0]      req_ack_number,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_frame_valid,
   output logic [FRAME_W-1:0]         rsp_frame_number,
   output logic                       rsp_is_retransmit,
   output logic                       rsp_bad_ack,
   output logic                       rsp_all_done,
   output logic                       rsp_last,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   // Command and status bundles between the controller and the datapath.
   srs_cmd_type  cmd;
   srs_stat_type stat;

   // Register writes are always taken; user must write only while idle (unchecked).
   assign csr_ready = 1'b1;

   // The controller walks each transaction through its phases: the slide of the
   // window base past acknowledged frames, the retransmission scan from the base up
   // to the next new frame (both for acks), the new-frame sends, the status result.
   srs_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .stat          (stat),
      .cmd           (cmd)
   );

   // The datapath holds the window state and the acknowledged bitmap, and a result
   // register that decouples the result channel from the work in progress.
   srs_datapath #(
      .MAX_FRAMES (MAX_FRAMES),
      .MAX_WINDOW (MAX_WINDOW)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_operation     (req_operation),
      .req_ack_number    (req_ack_number),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_valid   (rsp_frame_valid),
      .rsp_frame_number  (rsp_frame_number),
      .rsp_is_retransmit (rsp_is_retransmit),
      .rsp_bad_ack       (rsp_bad_ack),
      .rsp_all_done      (rsp_all_done),
      .rsp_last          (rsp_last)
   );

   // The status result never carries a frame.
   a_status_no_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !rsp_frame_valid)
      else $error("status result carries a frame");

   // Once every frame is acknowledged, no frame is sent any more.
   a_no_frame_when_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_valid |-> !rsp_all_done)
      else $error("frame sent after completion");

   // While waiting for a request, only a status result can still be pending.
   a_idle_only_status: assert property (@(posedge clock) disable iff (reset)
      req_ready && rsp_valid |-> rsp_last)
      else $error("frame result pending while idle");

   // A transaction always has at least its status result to produce.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken again without a status result");

endmodule

`default_nettype wire

[rtl/core/srs_datapath.sv]
// Datapath of the selective-repeat sender: window registers, acknowledged
// bitmap, scan pointer, configuration registers and the result register.
// Depends on srs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srs_datapath
   import srs_pkg::*;
#(
   parameter int unsigned MAX_FRAMES = 16,
   parameter int unsigned MAX_WINDOW = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire srs_cmd_type           cmd,
   output srs_stat_type               stat,
   input  wire logic [OP_W-1:0]       req_operation,
   input  wire logic [ACK_W-1:0]      req_ack_number,
   input  wire logic                  csr_valid,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_frame_valid,
   output logic [FRAME_W-1:0]         rsp_frame_number,
   output logic                       rsp_is_retransmit,
   output logic                       rsp_bad_ack,
   output logic                       rsp_all_done,
   output logic                       rsp_last
);

   localparam int unsigned CW = $clog2(MAX_FRAMES + 1);
   localparam int unsigned AW = $clog2(MAX_FRAMES);
   localparam int unsigned LW = CW + 5;

   logic [WIN_W-1:0]      window_size_ff;
   logic [END_W-1:0]      frame_end_ff;
   logic [CW-1:0]         base_ff;
   logic [CW-1:0]         next_new_ff;
   logic [CW-1:0]         ptr_ff;
   logic [MAX_FRAMES-1:0] acked_ff;
   logic                  bad_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_frame_valid_ff;
   logic [FRAME_W-1:0]    rsp_frame_number_ff;
   logic                  rsp_is_retransmit_ff;
   logic                  rsp_bad_ack_ff;
   logic                  rsp_all_done_ff;
   logic                  rsp_last_ff;

   logic [LW-1:0] fe_x;
   logic [LW-1:0] end_x;
   logic [LW-1:0] ws_x;
   logic [LW-1:0] win_x;
   logic [LW-1:0] ack_x;
   logic [LW-1:0] base_x;
   logic [LW-1:0] next_x;
   logic [LW-1:0] ptr_x;
   logic          bad_now;
   logic          in_range;
   logic          acked_bit;
   logic          done;

   // Registers are used saturated to their legal ranges.
   always_comb begin
      fe_x  = LW'(frame_end_ff);
      ws_x  = LW'(window_size_ff);
      end_x = (fe_x < LW'(2)) ? LW'(2) :
              ((fe_x > LW'(MAX_FRAMES)) ? LW'(MAX_FRAMES) : fe_x);
      win_x = (ws_x == '0) ? LW'(1) :
              ((ws_x > LW'(MAX_WINDOW)) ? LW'(MAX_WINDOW) : ws_x);
   end

   assign ack_x   = LW'(req_ack_number);
   assign base_x  = LW'(base_ff);
   assign next_x  = LW'(next_new_ff);
   assign ptr_x   = LW'(ptr_ff);
   assign bad_now = (req_operation == OP_ACK) && ((ack_x == '0) || (ack_x >= end_x));

   // The pointer tracks the base during the slide, so one read port serves both scans.
   assign in_range  = ptr_x < end_x;
   assign acked_bit = in_range ? acked_ff[ptr_ff[AW-1:0]] : 1'b0;
   assign done      = base_x >= end_x;

   always_comb begin
      stat.slide_more = in_range && acked_bit;
      stat.retx_more  = in_range && (ptr_x < next_x);
      stat.retx_hit   = !acked_bit;
      stat.new_more   = (next_x < end_x) && (next_x < base_x + win_x);
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WINDOW_SIZE_RST;
         frame_end_ff   <= FRAME_END_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WINDOW_SIZE: window_size_ff <= csr_data[WIN_W-1:0];
            CSR_FRAME_END:   frame_end_ff   <= csr_data[END_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff     <= CW'(1);
         next_new_ff <= CW'(1);
         acked_ff    <= '0;
      end else begin
         if (cmd.accept && !bad_now && (req_operation == OP_ACK)) begin
            acked_ff[ack_x[AW-1:0]] <= 1'b1;
         end
         if (cmd.slide_step) begin
            base_ff <= base_ff + CW'(1);
         end
         if (cmd.raise && (next_new_ff < base_ff)) begin
            next_new_ff <= base_ff;
         end
         if (cmd.new_step) begin
            next_new_ff <= next_new_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ptr_ff <= base_ff;
         bad_ff <= bad_now;
      end else if (cmd.slide_step || cmd.scan_step) begin
         ptr_ff <= ptr_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_frame_valid_ff   <= cmd.kind != KIND_STATUS;
         rsp_is_retransmit_ff <= cmd.kind == KIND_RETX;
         rsp_last_ff          <= cmd.kind == KIND_STATUS;
         rsp_bad_ack_ff       <= bad_ff;
         rsp_all_done_ff      <= done;
         case (cmd.kind)
            KIND_RETX: rsp_frame_number_ff <= ptr_x[FRAME_W-1:0];
            KIND_NEW:  rsp_frame_number_ff <= next_x[FRAME_W-1:0];
            default:   rsp_frame_number_ff <= '0;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_valid   = rsp_frame_valid_ff;
   assign rsp_frame_number  = rsp_frame_number_ff;
   assign rsp_is_retransmit = rsp_is_retransmit_ff;
   assign rsp_bad_ack       = rsp_bad_ack_ff;
   assign rsp_all_done      = rsp_all_done_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

`default_nettype wire

[rtl/core/srs_ctrl.sv]
// Controller of the selective-repeat sender: sequences accept, slide,
// retransmit scan, new-frame sends and the status result.
// Depends on srs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srs_ctrl
   import srs_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire logic [OP_W-1:0] req_operation,
   input  wire srs_stat_type    stat,
   output srs_cmd_type          cmd
);

   srs_state_type state_ff;
   srs_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.kind  = KIND_STATUS;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = (req_operation == OP_ACK) ? ST_SLIDE : ST_NEW;
            end
         end
         ST_SLIDE: begin
            if (stat.slide_more) begin
               cmd.slide_step = 1'b1;
            end else begin
               cmd.raise = 1'b1;
               state_in  = ST_RETX;
            end
         end
         ST_RETX: begin
            if (!stat.retx_more) begin
               state_in = ST_NEW;
            end else if (!stat.retx_hit) begin
               cmd.scan_step = 1'b1;
            end else if (stat.out_free) begin
               cmd.scan_step = 1'b1;
               cmd.emit      = 1'b1;
               cmd.kind      = KIND_RETX;
            end
         end
         ST_NEW: begin
            if (!stat.new_more) begin
               state_in = ST_STATUS;
            end else if (stat.out_free) begin
               cmd.new_step = 1'b1;
               cmd.emit     = 1'b1;
               cmd.kind     = KIND_NEW;
            end
         end
         ST_STATUS: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = KIND_STATUS;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for selective_repeat_sender_unit: directed and random
// acknowledgement traffic, register changes between phases, random stalls.
// Depends on srs_pkg and the RTL of the sender unit only.
`timescale 1ns / 1ps

module testbench;
   import srs_pkg::*;

   // Sizes the unit is built with; the predictor uses the same ones.
   localparam int unsigned FRAME_SLOTS = 16;
   localparam int unsigned WINDOW_CAP  = 8;
   // Generous ceiling on the run length, in clock cycles.
   localparam int unsigned CYCLE_LIMIT = 500000;
   // Random requests issued in each register phase.
   localparam int unsigned PHASE_ITEMS = 45;
   // Results seen before the receiver starts its long hold-off, and its length.
   // The hold-off falls inside the random phases, where the driver keeps offering.
   localparam int unsigned HOLD_AFTER   = 150;
   localparam int unsigned HOLD_CYCLES  = 300;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [ACK_W-1:0] ack;
   } sender_request_type;

   typedef struct packed {
      logic               frame_valid;
      logic [FRAME_W-1:0] frame_number;
      logic               is_retransmit;
      logic               bad_ack;
      logic               all_done;
      logic               last;
   } frame_report_type;

   // The receiver switches between these stall patterns at random intervals.
   typedef enum logic [1:0] {
      RX_STEADY,
      RX_COIN,
      RX_EVERY_THIRD,
      RX_MOSTLY
   } stall_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid      = 1'b0;
   logic                  req_ready;
   logic [OP_W-1:0]       req_operation  = OP_START;
   logic [ACK_W-1:0]      req_ack_number = '0;
   logic                  rsp_valid;
   logic                  rsp_ready      = 1'b0;
   logic                  rsp_frame_valid;
   logic [FRAME_W-1:0]    rsp_frame_number;
   logic                  rsp_is_retransmit;
   logic                  rsp_bad_ack;
   logic                  rsp_all_done;
   logic                  rsp_last;
   logic                  csr_valid      = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index      = CSR_WINDOW_SIZE;
   logic [CSR_DATA_W-1:0] csr_data       = '0;

   selective_repeat_sender_unit #(
      .MAX_FRAMES (FRAME_SLOTS),
      .MAX_WINDOW (WINDOW_CAP)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_ack_number    (req_ack_number),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_valid   (rsp_frame_valid),
      .rsp_frame_number  (rsp_frame_number),
      .rsp_is_retransmit (rsp_is_retransmit),
      .rsp_bad_ack       (rsp_bad_ack),
      .rsp_all_done      (rsp_all_done),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #6 clock = ~clock;

   // Requests waiting for the driver, and the results the unit still owes us,
   // oldest first.
   sender_request_type request_backlog [$];
   frame_report_type   due_frames [$];

   // Our own picture of the sender: the oldest frame not yet acknowledged, the
   // next frame never sent, the acknowledged flags, and the two registers as
   // written (saturation is applied when they are used).
   int unsigned    oldest_open = 1;
   int unsigned    next_fresh  = 1;
   logic           acked_flags [FRAME_SLOTS];
   logic [WIN_W-1:0] window_reg = WINDOW_SIZE_RST;
   logic [END_W-1:0] limit_reg  = FRAME_END_RST;

   // Run statistics and the failure count.
   int unsigned error_count   = 0;
   int unsigned cycle_count   = 0;
   int unsigned request_count = 0;
   int unsigned ack_count     = 0;
   int unsigned ignored_count = 0;
   int unsigned results_seen  = 0;
   int unsigned retx_count    = 0;
   int unsigned fresh_count   = 0;
   int unsigned csr_writes    = 0;

   // Set by the monitor at each rising edge when the request channel completed
   // a transaction; the driver reads it at the falling edge that follows.
   logic req_taken = 1'b0;

   initial begin
      foreach (acked_flags[i]) acked_flags[i] = 1'b0;
   end

   function automatic int unsigned effective_limit();
      int unsigned lim;
      lim = limit_reg;
      if (lim < 2) lim = 2;
      if (lim > FRAME_SLOTS) lim = FRAME_SLOTS;
      return lim;
   endfunction

   function automatic int unsigned effective_window();
      int unsigned span;
      span = window_reg;
      if (span < 1) span = 1;
      if (span > WINDOW_CAP) span = WINDOW_CAP;
      return span;
   endfunction

   // Works out every result one accepted request causes and appends them to
   // the queue of owed results. Retransmissions come first, in ascending
   // order, then first sends, then a single status result that closes the
   // transaction group.
   task automatic predict_sender_step(input logic [OP_W-1:0] op,
                                      input logic [ACK_W-1:0] ack);
      int unsigned      lim;
      int unsigned      span;
      logic             ignored;
      logic             finished;
      frame_report_type step_out [$];
      frame_report_type one;
      lim = effective_limit();
      span = effective_window();
      ignored = 1'b0;
      request_count++;
      if (op == OP_ACK) begin
         ack_count++;
         // Frame zero and anything at or past the limit are rejected, but the
         // slide and the retransmission scan still run.
         if (ack == 0 || ack >= lim) begin
            ignored = 1'b1;
            ignored_count++;
         end else begin
            acked_flags[ack] = 1'b1;
         end
         while (oldest_open < lim && acked_flags[oldest_open]) oldest_open++;
         // Early acknowledgements can carry the base beyond the next new frame.
         if (next_fresh < oldest_open) next_fresh = oldest_open;
         // The scan covers everything in flight below the limit, whatever the
         // window has since been set to.
         for (int unsigned f = oldest_open; f < next_fresh && f < lim; f++) begin
            if (!acked_flags[f]) begin
               one = '0;
               one.frame_valid = 1'b1;
               one.frame_number = f[FRAME_W-1:0];
               one.is_retransmit = 1'b1;
               step_out.push_back(one);
               retx_count++;
            end
         end
      end
      while (next_fresh < oldest_open + span && next_fresh < lim) begin
         one = '0;
         one.frame_valid = 1'b1;
         one.frame_number = next_fresh[FRAME_W-1:0];
         step_out.push_back(one);
         fresh_count++;
         next_fresh++;
      end
      finished = (oldest_open >= lim);
      one = '0;
      one.last = 1'b1;
      step_out.push_back(one);
      foreach (step_out[k]) begin
         step_out[k].bad_ack = ignored;
         step_out[k].all_done = finished;
         due_frames.push_back(step_out[k]);
      end
   endtask

   // Random request shaped around the current window: mostly acknowledgements
   // of frames in flight (which includes duplicates), some early ones for
   // frames not sent yet, some starts, and the rest arbitrary noise.
   function automatic sender_request_type pick_random_request();
      sender_request_type r;
      int unsigned        lim;
      int unsigned        pick;
      lim = effective_limit();
      pick = $urandom_range(0, 99);
      r.op = OP_ACK;
      r.ack = ACK_W'($urandom_range(0, 15));
      if (pick < 15) begin
         r.op = OP_START;
      end else if (pick < 70 && next_fresh > oldest_open) begin
         r.ack = ACK_W'($urandom_range(oldest_open, next_fresh - 1));
      end else if (pick < 80 && next_fresh < lim) begin
         r.ack = ACK_W'($urandom_range(next_fresh, lim - 1));
      end else if ($urandom_range(0, 1) == 0) begin
         r.op = OP_START;
      end
      return r;
   endfunction

   task automatic queue_request(input logic [OP_W-1:0] op, input int unsigned ack);
      sender_request_type r;
      r.op = op;
      r.ack = ack[ACK_W-1:0];
      request_backlog.push_back(r);
   endtask

   // Register writes are only made once the unit has nothing left to do: no
   // request waiting or on the wires, and every owed result delivered.
   task automatic wait_until_idle();
      while (request_backlog.size() != 0 || req_valid || due_frames.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input int unsigned value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_settings(input int unsigned span, input int unsigned lim);
      wait_until_idle();
      write_register(CSR_WINDOW_SIZE, span);
      write_register(CSR_FRAME_END, lim);
   endtask

   // Feeds random requests one at a time, so each is chosen from a view of
   // the window that is at most a transaction or two old.
   task automatic run_random(input int unsigned count);
      repeat (count) begin
         while (request_backlog.size() != 0) @(posedge clock);
         request_backlog.push_back(pick_random_request());
      end
   endtask

   // Driver. The sender works in bursts of random length with random gaps in
   // between; about a third of the gaps are empty, giving long unbroken runs.
   // A new request is only presented once the previous one has been taken.
   int unsigned burst_left = 0;
   int unsigned gap_left   = 0;

   always @(negedge clock) begin
      sender_request_type cur;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (request_backlog.size() != 0) begin
            cur = request_backlog.pop_front();
            req_operation <= cur.op;
            req_ack_number <= cur.ack;
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver. It stalls on a pattern of its own, changed at random times, and
   // once in the run holds off completely for a long stretch so
   // that the unit backs up and stops taking requests while the driver keeps
   // offering them.
   stall_mode_type rx_mode      = RX_STEADY;
   int unsigned    rx_mode_left = 0;
   int unsigned    rx_tick      = 0;
   int unsigned    hold_left    = 0;
   logic           hold_done    = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode = stall_mode_type'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(10, 60);
         end else begin
            rx_mode_left--;
         end
         rx_tick++;
         case (rx_mode)
            RX_STEADY:      rsp_ready <= 1'b1;
            RX_COIN:        rsp_ready <= ($urandom_range(0, 1) == 1);
            RX_EVERY_THIRD: rsp_ready <= (rx_tick % 3 != 0);
            default:        rsp_ready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // Monitor. Everything is sampled at the rising edge: results are checked
   // against the oldest owed result first, then register writes update the
   // predictor, then an accepted request is predicted.
   always @(posedge clock) begin
      frame_report_type got;
      frame_report_type want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            got.frame_valid = rsp_frame_valid;
            got.frame_number = rsp_frame_number;
            got.is_retransmit = rsp_is_retransmit;
            got.bad_ack = rsp_bad_ack;
            got.all_done = rsp_all_done;
            got.last = rsp_last;
            if (due_frames.size() == 0) begin
               error_count++;
               if (error_count <= 40)
                  $display("%0t: unexpected result, expected none, got %p", $time, got);
            end else begin
               want = due_frames.pop_front();
               if (got !== want) begin
                  error_count++;
                  if (error_count <= 40)
                     $display("%0t: result mismatch, expected %p, got %p",
                              $time, want, got);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            csr_writes++;
            if (csr_index == CSR_WINDOW_SIZE) window_reg = csr_data[WIN_W-1:0];
            else if (csr_index == CSR_FRAME_END) limit_reg = csr_data[END_W-1:0];
         end
         req_taken = req_valid && req_ready;
         if (req_taken) predict_sender_step(req_operation, req_ack_number);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results still owed",
                  $time, cycle_count, due_frames.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // Register settings of the random phases. The limit rises a little at a
   // time so that the fifteen usable frames are spread over several phases;
   // the last few phases use out-of-range values that saturate, and run
   // after the transfer has finished for good.
   int unsigned phase_window [9] = '{0, 8, 2, 7, 3, 15, 5, 6, 4};
   int unsigned phase_limit  [9] = '{12, 13, 14, 15, 16, 31, 0, 1, 2};

   // Stimulus sequence.
   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // With the reset settings (window four, frames one to nine).
      queue_request(OP_START, 0);     // fills the window with frames one to four
      queue_request(OP_START, 15);    // a start mid-transfer sends nothing new
      queue_request(OP_ACK, 0);       // frame zero is rejected
      queue_request(OP_ACK, 15);      // beyond the limit, rejected
      queue_request(OP_ACK, 10);      // exactly the limit, rejected
      queue_request(OP_ACK, 2);       // out of order: one, three, four go again
      queue_request(OP_ACK, 3);
      queue_request(OP_ACK, 6);       // early: frame six has not been sent
      queue_request(OP_ACK, 5);
      queue_request(OP_ACK, 1);       // base slides to four; five to seven go out
      queue_request(OP_ACK, 8);
      queue_request(OP_ACK, 9);
      queue_request(OP_ACK, 7);
      queue_request(OP_ACK, 4);       // base jumps past the next new frame to the end
      queue_request(OP_START, 0);     // after completion only status comes back
      queue_request(OP_ACK, 9);       // duplicate after completion
      queue_request(OP_ACK, 0);

      // Raise the limit with the widest window, then shrink the window while
      // frames are in flight, then lower the limit below some of them.
      apply_settings(15, 13);
      queue_request(OP_START, 0);
      apply_settings(0, 13);
      queue_request(OP_ACK, 11);
      apply_settings(0, 11);
      queue_request(OP_ACK, 12);

      foreach (phase_window[p]) begin
         apply_settings(phase_window[p], phase_limit[p]);
         run_random(PHASE_ITEMS);
      end

      while (request_backlog.size() != 0 || req_valid) @(posedge clock);
      while (due_frames.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Ran %0d requests (%0d acknowledgements, %0d of them rejected) over %0d",
               request_count, ack_count, ignored_count, csr_writes);
      $display("register writes; %0d results, %0d retransmissions, %0d first sends.",
               results_seen, retx_count, fresh_count);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
